// ===== design/qvr_pkg.sv =====
package qvr_pkg;

  // default field sizes
  localparam int unsigned COMP_WIDTH_DEF     = 16;
  localparam int unsigned QUAT_FRAC_BITS_DEF = 14;

  // register stages from input beat to output register
  localparam int unsigned NUM_STAGES = 6;

endpackage

// ===== design/quaternion_vector_rotate_core.sv =====
// Quaternion vector rotation, fully pipelined.
//
// Input channel (in_valid / in_stall): one beat carries a quaternion
// (in_quat_w/x/y/z, signed, QUAT_FRAC_BITS fraction bits) and a vector
// (in_vec_x/y/z, signed integers). Output channel (out_valid / out_stall):
// one beat per input beat, in order, with the rotated vector q*v*conj(q)
// rounded half up to integers and saturated to COMP_WIDTH bits each;
// out_clipped flags that at least one component saturated.
//
// The register stages, in order, are products, first sums, split second
// products, second sums, rounding and saturation. Throughput is one beat
// per cycle while the output is not stalled.
//
// Every stage holds its own valid bit. A stalled output holds its beat;
// earlier stages keep filling empty slots, so in_stall rises only once the
// whole pipe is full behind a stalled output. Nothing is stored between
// beats. A synchronous reset (rst_n low) empties the pipe.
module quaternion_vector_rotate_core
  import qvr_pkg::*;
#(
  parameter int unsigned COMP_WIDTH     = COMP_WIDTH_DEF,
  parameter int unsigned QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] in_quat_w,
  input  logic signed [COMP_WIDTH-1:0] in_quat_x,
  input  logic signed [COMP_WIDTH-1:0] in_quat_y,
  input  logic signed [COMP_WIDTH-1:0] in_quat_z,
  input  logic signed [COMP_WIDTH-1:0] in_vec_x,
  input  logic signed [COMP_WIDTH-1:0] in_vec_y,
  input  logic signed [COMP_WIDTH-1:0] in_vec_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_rot_x,
  output logic signed [COMP_WIDTH-1:0] out_rot_y,
  output logic signed [COMP_WIDTH-1:0] out_rot_z,
  output logic                         out_clipped
);

  localparam int unsigned CW   = COMP_WIDTH;
  localparam int unsigned SH   = 2 * QUAT_FRAC_BITS;
  localparam int unsigned PW   = 2 * CW;        // q * v
  localparam int unsigned TW   = 2 * CW + 2;    // first sums
  localparam int unsigned HPW  = 2 * CW + 1;    // q * upper half of t
  localparam int unsigned LPW  = 2 * CW + 2;    // q * lower half of t
  localparam int unsigned HSW  = 2 * CW + 3;
  localparam int unsigned LSW  = 2 * CW + 4;
  localparam int unsigned RW_A = 3 * CW + 6;
  localparam int unsigned RW   = (RW_A > SH + 2) ? RW_A : SH + 2;

  localparam logic signed [RW-1:0] BIAS = RW'(1) << (SH - 1);
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // index helpers for rot_c = w*t_c + q_c*t0 + q_b*t_d - q_d*t_b
  localparam int unsigned IDX_B [3] = '{2, 3, 1};
  localparam int unsigned IDX_D [3] = '{3, 1, 2};

  // handshake chain
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES-1:0] stage_en;

  always_comb begin
    stage_en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
    vld_nxt = {vld_r[NUM_STAGES-2:0], in_valid};
  end

  assign in_stall = !stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // stage 1: q * v products, quaternion carried along
  logic signed [CW-1:0] q1_r [4], q1_nxt [4];
  logic signed [PW-1:0] p1_r [12], p1_nxt [12];

  always_comb begin
    q1_nxt[0] = in_quat_w;
    q1_nxt[1] = in_quat_x;
    q1_nxt[2] = in_quat_y;
    q1_nxt[3] = in_quat_z;
    p1_nxt[0]  = in_vec_x * in_quat_x;
    p1_nxt[1]  = in_vec_y * in_quat_y;
    p1_nxt[2]  = in_vec_z * in_quat_z;
    p1_nxt[3]  = in_quat_w * in_vec_x;
    p1_nxt[4]  = in_vec_y * in_quat_z;
    p1_nxt[5]  = in_vec_z * in_quat_y;
    p1_nxt[6]  = in_quat_w * in_vec_y;
    p1_nxt[7]  = in_vec_z * in_quat_x;
    p1_nxt[8]  = in_vec_x * in_quat_z;
    p1_nxt[9]  = in_quat_w * in_vec_z;
    p1_nxt[10] = in_vec_x * in_quat_y;
    p1_nxt[11] = in_vec_y * in_quat_x;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      q1_r <= q1_nxt;
      p1_r <= p1_nxt;
    end
  end

  // stage 2: t = v * conj(q)
  logic signed [CW-1:0] q2_r [4];
  logic signed [TW-1:0] t2_r [4], t2_nxt [4];

  always_comb begin
    t2_nxt[0] = TW'(p1_r[0]) + TW'(p1_r[1]) + TW'(p1_r[2]);
    t2_nxt[1] = TW'(p1_r[3]) - TW'(p1_r[4]) + TW'(p1_r[5]);
    t2_nxt[2] = TW'(p1_r[6]) - TW'(p1_r[7]) + TW'(p1_r[8]);
    t2_nxt[3] = TW'(p1_r[9]) - TW'(p1_r[10]) + TW'(p1_r[11]);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      q2_r <= q1_r;
      t2_r <= t2_nxt;
    end
  end

  // stage 3: q * t, t split into a signed upper and an unsigned lower half
  logic signed [CW:0]    th [4];
  logic signed [CW+1:0]  tl [4];
  logic signed [HPW-1:0] ph3_r [3][4], ph3_nxt [3][4];
  logic signed [LPW-1:0] pl3_r [3][4], pl3_nxt [3][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      th[i] = t2_r[i][TW-1:CW+1];
      tl[i] = $signed({1'b0, t2_r[i][CW:0]});
    end
    for (int c = 0; c < 3; c++) begin
      ph3_nxt[c][0] = q2_r[0] * th[c+1];
      ph3_nxt[c][1] = q2_r[c+1] * th[0];
      ph3_nxt[c][2] = q2_r[IDX_B[c]] * th[IDX_D[c]];
      ph3_nxt[c][3] = q2_r[IDX_D[c]] * th[IDX_B[c]];
      pl3_nxt[c][0] = q2_r[0] * tl[c+1];
      pl3_nxt[c][1] = q2_r[c+1] * tl[0];
      pl3_nxt[c][2] = q2_r[IDX_B[c]] * tl[IDX_D[c]];
      pl3_nxt[c][3] = q2_r[IDX_D[c]] * tl[IDX_B[c]];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      ph3_r <= ph3_nxt;
      pl3_r <= pl3_nxt;
    end
  end

  // stage 4: per-component partial sums
  logic signed [HSW-1:0] hs4_r [3], hs4_nxt [3];
  logic signed [LSW-1:0] ls4_r [3], ls4_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hs4_nxt[c] = HSW'(ph3_r[c][0]) + HSW'(ph3_r[c][1])
                 + HSW'(ph3_r[c][2]) - HSW'(ph3_r[c][3]);
      ls4_nxt[c] = LSW'(pl3_r[c][0]) + LSW'(pl3_r[c][1])
                 + LSW'(pl3_r[c][2]) - LSW'(pl3_r[c][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      hs4_r <= hs4_nxt;
      ls4_r <= ls4_nxt;
    end
  end

  // stage 5: recombine halves, round half up
  logic signed [RW-1:0] sum5 [3];
  logic signed [RW-1:0] rnd5_r [3], rnd5_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum5[c]     = (RW'(hs4_r[c]) <<< (CW + 1)) + RW'(ls4_r[c]) + BIAS;
      rnd5_nxt[c] = sum5[c] >>> SH;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      rnd5_r <= rnd5_nxt;
    end
  end

  // stage 6: saturate into the output register
  logic                 fits [3];
  logic signed [CW-1:0] rot6_r [3], rot6_nxt [3];
  logic                 clip6_r, clip6_nxt;

  always_comb begin
    clip6_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      fits[c] = (rnd5_r[c][RW-1:CW-1] == '0) || (rnd5_r[c][RW-1:CW-1] == '1);
      if (fits[c]) begin
        rot6_nxt[c] = rnd5_r[c][CW-1:0];
      end else begin
        rot6_nxt[c] = rnd5_r[c][RW-1] ? SAT_MIN : SAT_MAX;
        clip6_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      rot6_r  <= rot6_nxt;
      clip6_r <= clip6_nxt;
    end
  end

  assign out_valid   = vld_r[NUM_STAGES-1];
  assign out_rot_x   = rot6_r[0];
  assign out_rot_y   = rot6_r[1];
  assign out_rot_z   = rot6_r[2];
  assign out_clipped = clip6_r;

endmodule

// ===== design/qvr_checker.sv =====
module qvr_checker
  import qvr_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COMP_WIDTH-1:0] out_rot_x,
  input logic signed [COMP_WIDTH-1:0] out_rot_y,
  input logic signed [COMP_WIDTH-1:0] out_rot_z,
  input logic                         out_clipped
);

  localparam logic signed [COMP_WIDTH-1:0] SAT_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [COMP_WIDTH-1:0] SAT_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  // a stalled output beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rot_x) && $stable(out_rot_y)
      && $stable(out_rot_z) && $stable(out_clipped))
    else $error("stalled output beat changed");

  // with an empty output slot the pipe always takes input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output slot empty");

  // a clipped beat has at least one component at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_rot_x == SAT_MAX || out_rot_x == SAT_MIN ||
      out_rot_y == SAT_MAX || out_rot_y == SAT_MIN ||
      out_rot_z == SAT_MAX || out_rot_z == SAT_MIN)
    else $error("clipped set with no saturated component");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind quaternion_vector_rotate_core qvr_checker #(
  .COMP_WIDTH(COMP_WIDTH)
) u_qvr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_rot_x  (out_rot_x),
  .out_rot_y  (out_rot_y),
  .out_rot_z  (out_rot_z),
  .out_clipped(out_clipped)
);
